// File: sv/i2cdbw_pkg.sv
package i2cdbw_pkg;

    // Depth of the small queues on either side of the sequencer.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Control bytes that precede the payload.
    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;

    // Register reset values.
    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'd120;
    localparam logic [7:0] ACK_TIMEOUT_RESET   = 8'd250;

    // Action codes on the input word.
    localparam logic [1:0] ACTION_TICK    = 2'd0;
    localparam logic [1:0] ACTION_COMMAND = 2'd1;
    localparam logic [1:0] ACTION_DATA    = 2'd2;

    // Configuration register indexes.
    typedef enum logic {
        CFG_SLAVE_ADDRESS = 1'b0,
        CFG_ACK_TIMEOUT   = 1'b1
    } t_cfg_index;

    // Classified request carried by one tick.
    typedef enum logic [1:0] {
        REQ_NONE,
        REQ_COMMAND,
        REQ_DATA
    } t_req;

    typedef struct packed {
        t_req       req;
        logic [7:0] payload;
        logic       sda;
    } t_tick;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic busy;
        logic done;
        logic failed;
    } t_result;

    // Handshake between the front queue and the sequencer.
    typedef struct packed {
        logic valid;
        t_tick tick;
    } t_tick_chan;

    // Bus sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_STOP_A,
        PH_STOP_B
    } t_phase;

endpackage

// File: sv/i2cdbw_fifo.sv
module i2cdbw_fifo
    import i2cdbw_pkg::*;
#(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign w_push    = i_wr_en && !o_full;
    assign w_pop     = i_rd_en && !o_empty;

    // Storage words need no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: sv/i2cdbw_front.sv
module i2cdbw_front
    import i2cdbw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [1:0] i_action,
    input  logic [7:0] i_payload,
    input  logic       i_sda_in,
    output logic       o_full,
    input  logic       i_tick_pop,
    output t_tick_chan o_tick
);

    t_tick w_class;
    t_tick w_head;
    logic  w_empty;

    // Decode the action; unused codes are plain ticks.
    always_comb begin
        w_class.payload = i_payload;
        w_class.sda     = i_sda_in;
        unique case (i_action)
            ACTION_COMMAND: w_class.req = REQ_COMMAND;
            ACTION_DATA:    w_class.req = REQ_DATA;
            default:        w_class.req = REQ_NONE;
        endcase
    end

    // Classified ticks wait here for the sequencer.
    i2cdbw_fifo #(
        .WIDTH($bits(t_tick))
    ) u_tick_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (i_push),
        .i_wr_data (w_class),
        .i_rd_en   (i_tick_pop),
        .o_rd_data (w_head),
        .o_full    (o_full),
        .o_empty   (w_empty)
    );

    assign o_tick.valid = !w_empty;
    assign o_tick.tick  = w_head;

endmodule

// File: sv/i2cdbw_seq.sv
module i2cdbw_seq
    import i2cdbw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  t_tick_chan i_tick,
    input  logic       i_res_full,
    output logic       o_step,
    output t_result    o_res
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [2:0] r_bit_count;
    logic [2:0] n_bit_count;
    logic [7:0] r_shift;
    logic [7:0] n_shift;
    logic [1:0] r_byte_index;
    logic [1:0] n_byte_index;
    logic [7:0] r_held;
    logic [7:0] n_held;
    logic       r_is_data;
    logic       n_is_data;
    logic [8:0] r_poll_count;
    logic [8:0] n_poll_count;
    logic       r_error;
    logic       n_error;
    logic [7:0] r_slave_address;
    logic [7:0] r_ack_timeout;
    logic [8:0] w_poll_inc;
    logic       w_done;

    // One tick is processed when one is waiting and the result has room.
    assign o_step     = i_tick.valid && !i_res_full;
    assign w_poll_inc = r_poll_count + 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= SLAVE_ADDRESS_RESET;
            r_ack_timeout   <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SLAVE_ADDRESS: r_slave_address <= i_cfg_data;
                CFG_ACK_TIMEOUT:   r_ack_timeout   <= i_cfg_data;
                default:           r_ack_timeout   <= r_ack_timeout;
            endcase
        end
    end

    // Next-state logic of the bus sequencer.
    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_byte_index = r_byte_index;
        n_held       = r_held;
        n_is_data    = r_is_data;
        n_poll_count = r_poll_count;
        n_error      = r_error;
        w_done       = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_tick.tick.req != REQ_NONE) begin
                    n_held       = i_tick.tick.payload;
                    n_is_data    = (i_tick.tick.req == REQ_DATA);
                    n_error      = 1'b0;
                    n_byte_index = '0;
                    n_bit_count  = '0;
                    n_poll_count = '0;
                    n_shift      = {r_slave_address[7:1], 1'b0};
                    n_phase      = PH_START_A;
                end
            end
            PH_START_A: n_phase = PH_START_B;
            PH_START_B: n_phase = PH_BIT_LOW;
            PH_BIT_LOW: n_phase = PH_BIT_HIGH;
            PH_BIT_HIGH: begin
                n_shift     = {r_shift[6:0], 1'b0};
                n_bit_count = r_bit_count + 1'b1;
                n_phase     = (r_bit_count == 3'd7) ? PH_ACK_LOW : PH_BIT_LOW;
            end
            PH_ACK_LOW: begin
                n_poll_count = '0;
                n_phase      = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                // Ack seen, or a lapsed control-byte ack: go on to the next byte.
                if (!i_tick.tick.sda || ((w_poll_inc > {1'b0, r_ack_timeout})
                                         && (r_byte_index == 2'd1))) begin
                    if (!i_tick.tick.sda) begin
                        n_poll_count = r_poll_count;
                    end else begin
                        n_poll_count = '0;
                    end
                    if (r_byte_index == 2'd2) begin
                        n_phase = PH_STOP_A;
                    end else begin
                        n_byte_index = r_byte_index + 1'b1;
                        n_shift      = (r_byte_index == 2'd0)
                                       ? (r_is_data ? CTRL_DATA : CTRL_COMMAND)
                                       : r_held;
                        n_bit_count  = '0;
                        n_phase      = PH_BIT_LOW;
                    end
                end else if (w_poll_inc > {1'b0, r_ack_timeout}) begin
                    n_poll_count = '0;
                    n_error      = 1'b1;
                    n_phase      = PH_STOP_A;
                end else begin
                    n_poll_count = w_poll_inc;
                end
            end
            PH_STOP_A: n_phase = PH_STOP_B;
            PH_STOP_B: begin
                n_phase = PH_IDLE;
                w_done  = 1'b1;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // Pin levels follow the phase entered on this tick.
    always_comb begin
        o_res.busy   = (n_phase != PH_IDLE);
        o_res.done   = w_done;
        o_res.failed = w_done && r_error;
        unique case (n_phase)
            PH_START_A:  begin o_res.scl_level = 1'b1; o_res.sda_level = 1'b0;       end
            PH_START_B:  begin o_res.scl_level = 1'b0; o_res.sda_level = 1'b0;       end
            PH_BIT_LOW:  begin o_res.scl_level = 1'b0; o_res.sda_level = n_shift[7]; end
            PH_BIT_HIGH: begin o_res.scl_level = 1'b1; o_res.sda_level = n_shift[7]; end
            PH_ACK_LOW:  begin o_res.scl_level = 1'b0; o_res.sda_level = 1'b1;       end
            PH_ACK_HIGH: begin o_res.scl_level = 1'b1; o_res.sda_level = 1'b1;       end
            PH_STOP_A:   begin o_res.scl_level = 1'b0; o_res.sda_level = 1'b0;       end
            PH_STOP_B:   begin o_res.scl_level = 1'b1; o_res.sda_level = 1'b0;       end
            default:     begin o_res.scl_level = 1'b1; o_res.sda_level = 1'b1;       end
        endcase
    end

    // Sequencer state advances once per processed tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_shift      <= '0;
            r_byte_index <= '0;
            r_held       <= '0;
            r_is_data    <= 1'b0;
            r_poll_count <= '0;
            r_error      <= 1'b0;
        end else if (o_step) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_byte_index <= n_byte_index;
            r_held       <= n_held;
            r_is_data    <= n_is_data;
            r_poll_count <= n_poll_count;
            r_error      <= n_error;
        end
    end

    // The stop always returns the sequencer to idle.
    a_stop_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_step && r_phase == PH_STOP_B) |=> (r_phase == PH_IDLE))
        else $error("stop did not return to idle");

    // A failure is reported only together with done.
    a_fail_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step |-> (!o_res.failed || o_res.done))
        else $error("failure flagged without done");

    // Only three bytes go out per transfer.
    a_byte_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index != 2'd3)
        else $error("byte index out of range");

    // The poll counter never runs past one beyond the largest timeout.
    a_poll_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_poll_count <= 9'd256)
        else $error("poll counter overran");

endmodule

// File: sv/i2c_display_byte_writer.sv
// I2C display byte writer. Each word pushed is one half-bit tick of the bus;
// action 1 starts a command byte and action 2 a data byte, sent as start,
// write address, control byte, payload and stop, with the address and
// payload acks checked against the ack timeout. Every tick yields exactly one
// result word with the pin levels after that tick, busy, done and failed.
// Throughput is one tick per clock while the result queue has room; the
// sequencer sits between a two-word queue in front of it and a two-word
// result queue behind it, through which each tick and its result pass.
// Configuration writes are always ready and should be made while idle.
module i2c_display_byte_writer
    import i2cdbw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_action,
    input  logic [7:0] i_payload,
    input  logic       i_sda_in,
    output logic       empty,
    input  logic       pop,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_failed,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_tick_chan w_tick;
    t_result    w_res;
    t_result    w_res_head;
    logic       w_step;
    logic       w_res_full;

    assign o_cfg_ready = 1'b1;

    // Front end: accepts and classifies ticks.
    i2cdbw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_action   (i_action),
        .i_payload  (i_payload),
        .i_sda_in   (i_sda_in),
        .o_full     (full),
        .i_tick_pop (w_step),
        .o_tick     (w_tick)
    );

    // Back end: bus sequencer.
    i2cdbw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tick      (w_tick),
        .i_res_full  (w_res_full),
        .o_step      (w_step),
        .o_res       (w_res)
    );

    // Result queue toward the consumer.
    i2cdbw_fifo #(
        .WIDTH($bits(t_result))
    ) u_res_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_step),
        .i_wr_data (w_res),
        .i_rd_en   (pop),
        .o_rd_data (w_res_head),
        .o_full    (w_res_full),
        .o_empty   (empty)
    );

    assign o_scl_level = w_res_head.scl_level;
    assign o_sda_level = w_res_head.sda_level;
    assign o_busy_res  = w_res_head.busy;
    assign o_done_res  = w_res_head.done;
    assign o_failed    = w_res_head.failed;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import i2cdbw_pkg::*;

    // Action code that the block treats as a plain tick.
    localparam logic [1:0] ACTION_SPARE = 2'd3;
    localparam int STALL_LIMIT = 3000;
    localparam int TOTAL_TICKS = 1300;

    // One half-bit tick as it is pushed into the block.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] payload;
        logic       sda;
    } t_bus_tick;

    // Bus sequencer state as the testbench tracks it.
    typedef struct packed {
        t_phase     ph;
        logic [3:0] bit_no;
        logic [7:0] shreg;
        logic [1:0] byte_no;
        logic [7:0] pay;
        logic       data_sel;
        logic [8:0] polls;
        logic       err;
    } t_writer_state;

    typedef struct packed {
        t_writer_state nxt;
        t_result       res;
    } t_writer_step;

    localparam t_writer_state WRITER_RESET = '0;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [1:0] i_action = ACTION_TICK;
    logic [7:0] i_payload = 8'h00;
    logic       i_sda_in = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic       o_scl_level;
    logic       o_sda_level;
    logic       o_busy_res;
    logic       o_done_res;
    logic       o_failed;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_index cfg_index = CFG_SLAVE_ADDRESS;
    logic [7:0] i_cfg_data = 8'h00;

    // Register copies, the sequencer as seen by the generator and by the checker.
    logic [7:0]    addr_cfg = SLAVE_ADDRESS_RESET;
    logic [7:0]    limit_cfg = ACK_TIMEOUT_RESET;
    t_writer_state writer_plan = WRITER_RESET;
    t_writer_state writer_now = WRITER_RESET;
    t_writer_step  accept_step;
    t_result       want;

    t_bus_tick pending_ticks[$];
    t_result   expected_pins[$];

    int  ticks_queued = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  stall_cycles = 0;
    int  push_gap = 0;
    int  pop_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  word_taken = 1'b0;
    bit  push_idle_on = 1'b1;
    bit  pop_idle_on = 1'b1;

    i2c_display_byte_writer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_action    (i_action),
        .i_payload   (i_payload),
        .i_sda_in    (i_sda_in),
        .empty       (empty),
        .pop         (pop),
        .o_scl_level (o_scl_level),
        .o_sda_level (o_sda_level),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_failed    (o_failed),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advances the sequencer by one tick and gives the pin levels after it.
    function automatic t_writer_step step_writer(t_writer_state s, t_bus_tick t,
                                                 logic [7:0] addr, logic [7:0] limit);
        t_writer_step r;
        logic         ack_ok;
        r.res = '0;
        ack_ok = 1'b0;
        case (s.ph)
            PH_IDLE: begin
                if (t.action == ACTION_COMMAND || t.action == ACTION_DATA) begin
                    s.pay = t.payload;
                    s.data_sel = (t.action == ACTION_DATA);
                    s.err = 1'b0;
                    s.byte_no = 2'd0;
                    s.bit_no = 4'd0;
                    s.polls = 9'd0;
                    s.shreg = {addr[7:1], 1'b0};
                    s.ph = PH_START_A;
                end
            end
            PH_START_A: s.ph = PH_START_B;
            PH_START_B: s.ph = PH_BIT_LOW;
            PH_BIT_LOW: s.ph = PH_BIT_HIGH;
            PH_BIT_HIGH: begin
                s.shreg = s.shreg << 1;
                s.bit_no = s.bit_no + 4'd1;
                if (s.bit_no >= 4'd8) begin
                    s.bit_no = 4'd0;
                    s.ph = PH_ACK_LOW;
                end else begin
                    s.ph = PH_BIT_LOW;
                end
            end
            PH_ACK_LOW: begin
                s.polls = 9'd0;
                s.ph = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
                if (!t.sda) begin
                    ack_ok = 1'b1;
                end else begin
                    s.polls = s.polls + 9'd1;
                    if (s.polls > {1'b0, limit}) begin
                        s.polls = 9'd0;
                        // A missing ack on the control byte is tolerated.
                        if (s.byte_no == 2'd1) begin
                            ack_ok = 1'b1;
                        end else begin
                            s.err = 1'b1;
                            s.ph = PH_STOP_A;
                        end
                    end
                end
            end
            PH_STOP_A: s.ph = PH_STOP_B;
            PH_STOP_B: begin
                s.ph = PH_IDLE;
                r.res.done = 1'b1;
                r.res.failed = s.err;
            end
            default: s.ph = PH_IDLE;
        endcase

        // Move on to the control byte, then the payload, then the stop.
        if (ack_ok) begin
            if (s.byte_no >= 2'd2) begin
                s.ph = PH_STOP_A;
            end else begin
                s.byte_no = s.byte_no + 2'd1;
                if (s.byte_no == 2'd1) begin
                    s.shreg = s.data_sel ? CTRL_DATA : CTRL_COMMAND;
                end else begin
                    s.shreg = s.pay;
                end
                s.bit_no = 4'd0;
                s.ph = PH_BIT_LOW;
            end
        end

        case (s.ph)
            PH_START_A:  {r.res.scl_level, r.res.sda_level} = 2'b10;
            PH_START_B:  {r.res.scl_level, r.res.sda_level} = 2'b00;
            PH_BIT_LOW:  {r.res.scl_level, r.res.sda_level} = {1'b0, s.shreg[7]};
            PH_BIT_HIGH: {r.res.scl_level, r.res.sda_level} = {1'b1, s.shreg[7]};
            PH_ACK_LOW:  {r.res.scl_level, r.res.sda_level} = 2'b01;
            PH_ACK_HIGH: {r.res.scl_level, r.res.sda_level} = 2'b11;
            PH_STOP_A:   {r.res.scl_level, r.res.sda_level} = 2'b00;
            PH_STOP_B:   {r.res.scl_level, r.res.sda_level} = 2'b10;
            default:     {r.res.scl_level, r.res.sda_level} = 2'b11;
        endcase
        r.res.busy = (s.ph != PH_IDLE);
        r.nxt = s;
        return r;
    endfunction

    // Mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 70) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Number of high polls on one ack: often none, at times up to or past the limit.
    function automatic int pick_polls();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 0;
        end else if (r < 8) begin
            return (limit_cfg == 8'd0) ? 0 : $urandom_range(1, limit_cfg);
        end else if (r == 8) begin
            return int'(limit_cfg);
        end
        return int'(limit_cfg) + 1;
    endfunction

    // Queues one tick and keeps the generator's view of the sequencer in step.
    task automatic queue_tick(logic [1:0] action, logic [7:0] payload, logic sda);
        t_bus_tick    t;
        t_writer_step st;
        t = '{action: action, payload: payload, sda: sda};
        st = step_writer(writer_plan, t, addr_cfg, limit_cfg);
        writer_plan = st.nxt;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // Queues one whole transfer; SDA is held high for the given polls on each ack.
    // With noise, requests are also offered while busy and on the done tick.
    task automatic queue_transfer(logic [1:0] req, logic [7:0] pay, int addr_polls,
                                  int ctrl_polls, int data_polls, bit noisy);
        int         left[3];
        logic [1:0] act;
        logic       sda;
        left[0] = addr_polls;
        left[1] = ctrl_polls;
        left[2] = data_polls;
        while (writer_plan.ph != PH_IDLE) begin
            queue_tick(ACTION_TICK, 8'($urandom), 1'b0);
        end
        queue_tick(req, pay, 1'($urandom));
        while (writer_plan.ph != PH_IDLE) begin
            act = ACTION_TICK;
            sda = 1'($urandom_range(0, 1));
            if (noisy && $urandom_range(0, 3) == 0) begin
                act = 2'($urandom_range(0, 3));
            end
            if (noisy && writer_plan.ph == PH_STOP_B) begin
                act = 2'($urandom_range(1, 2));
            end
            if (writer_plan.ph == PH_ACK_HIGH) begin
                if (left[writer_plan.byte_no] > 0) begin
                    sda = 1'b1;
                    left[writer_plan.byte_no]--;
                end else begin
                    sda = 1'b0;
                end
            end
            queue_tick(act, 8'($urandom), sda);
        end
    endtask

    // Writes both registers back to back; valid stays high between the two words.
    task automatic set_regs(logic [7:0] addr, logic [7:0] limit);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        cfg_index <= CFG_SLAVE_ADDRESS;
        i_cfg_data <= addr;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        addr_cfg = addr;
        @(negedge i_clk);
        cfg_index <= CFG_ACK_TIMEOUT;
        i_cfg_data <= limit;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        limit_cfg = limit;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // The sender pauses here until every queued tick has come back.
    task automatic drain_all();
        while (pending_ticks.size() != 0 || expected_pins.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic check_pin(string field, logic exp_v, logic got_v);
        if (got_v !== exp_v) begin
            flag_mismatch($sformatf("word %0d: %s expected %b, got %b",
                                    results_seen, field, exp_v, got_v));
        end
    endtask

    // Stimulus: directed transfers, then random phases with fresh settings.
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a clean command, and a data byte whose control ack
        // times out at the default limit.
        queue_transfer(ACTION_COMMAND, 8'h00, 0, 0, 0, 1'b0);
        queue_transfer(ACTION_DATA, 8'hFF, 0, ACK_TIMEOUT_RESET + 1, 0, 1'b0);
        queue_tick(ACTION_SPARE, 8'h55, 1'b1);
        drain_all();

        // Zero timeout: any high poll counts. No idling in this stretch.
        push_idle_on = 1'b0;
        pop_idle_on = 1'b0;
        set_regs(8'hFF, 8'd0);
        queue_tick(ACTION_SPARE, 8'hFF, 1'b1);
        queue_tick(ACTION_TICK, 8'h00, 1'b0);
        queue_transfer(ACTION_COMMAND, 8'hA5, 1, 0, 0, 1'b1);
        queue_transfer(ACTION_DATA, 8'h5A, 0, 1, 0, 1'b1);
        queue_transfer(ACTION_COMMAND, 8'h3C, 0, 0, 1, 1'b0);
        queue_transfer(ACTION_DATA, 8'hC3, 0, 0, 0, 1'b1);
        drain_all();

        // Widest timeout: exactly at the limit passes, one more poll fails.
        push_idle_on = 1'b1;
        pop_idle_on = 1'b1;
        set_regs(8'h00, 8'd255);
        queue_transfer(ACTION_DATA, 8'h81, 0, 0, 255, 1'b0);
        queue_transfer(ACTION_COMMAND, 8'h7E, 256, 0, 0, 1'b1);
        drain_all();

        // Random phases with small timeouts so that failures stay cheap.
        while (ticks_queued < TOTAL_TICKS) begin
            set_regs(8'($urandom), 8'($urandom_range(0, 7)));
            push_idle_on = ($urandom_range(0, 3) != 0);
            pop_idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 4)) begin
                queue_transfer(2'($urandom_range(1, 2)), 8'($urandom),
                               pick_polls(), pick_polls(), pick_polls(),
                               1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 3)) begin
                    queue_tick($urandom_range(0, 1) ? ACTION_TICK : ACTION_SPARE,
                               8'($urandom), 1'($urandom_range(0, 1)));
                end
            end
            drain_all();
        end

        repeat (10) @(negedge i_clk);
        if (expected_pins.size() != 0) begin
            flag_mismatch($sformatf("%0d expected words never arrived", expected_pins.size()));
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Input side: a word accepted at this edge is run through the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            accept_step = step_writer(writer_now,
                                      '{action: i_action, payload: i_payload, sda: i_sda_in},
                                      addr_cfg, limit_cfg);
            writer_now = accept_step.nxt;
            expected_pins.push_back(accept_step.res);
            void'(pending_ticks.pop_front());
            word_taken = 1'b1;
        end
    end

    // Driver: holds a word until it is taken, then maybe pauses before the next.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!push || word_taken) begin
                word_taken = 1'b0;
                if (push_gap > 0) begin
                    push_gap--;
                    push <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    push <= 1'b1;
                    i_action <= pending_ticks[0].action;
                    i_payload <= pending_ticks[0].payload;
                    i_sda_in <= pending_ticks[0].sda;
                    push_gap = pick_gap(push_idle_on);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result side: one long hold-off while plenty is still queued, else random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && results_seen >= 300 && pending_ticks.size() > 40) begin
                hold_left = 150;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                pop_gap = pick_gap(pop_idle_on);
            end
        end
    end

    // Monitor: each popped word is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (expected_pins.size() == 0) begin
                flag_mismatch($sformatf("word %0d arrived with nothing expected: %b%b%b%b%b",
                                        results_seen, o_scl_level, o_sda_level,
                                        o_busy_res, o_done_res, o_failed));
            end else begin
                want = expected_pins.pop_front();
                check_pin("scl_level", want.scl_level, o_scl_level);
                check_pin("sda_level", want.sda_level, o_sda_level);
                check_pin("busy_res", want.busy, o_busy_res);
                check_pin("done_res", want.done, o_done_res);
                check_pin("failed", want.failed, o_failed);
            end
        end
    end

    // Watchdog: ends the run when nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
